### sv/bse_pkg.sv
// Package for the bubble sort engine: sizes, word types and sequencer states.
`default_nettype none

package bse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_res;
        logic                     overflow;
    } out_word_t;

    typedef enum logic [6:0] {
        S_LOAD    = 7'b000_0001,
        S_RD0     = 7'b000_0010,
        S_FIRST   = 7'b000_0100,
        S_CMP     = 7'b000_1000,
        S_TAIL    = 7'b001_0000,
        S_EMIT_RD = 7'b010_0000,
        S_EMIT    = 7'b100_0000
    } state_t;

endpackage

`default_nettype wire

### sv/bubble_sort_engine.sv
// Bubble sort engine: load a set of signed words, sort them in place, stream them out.
`default_nettype none

// Words of a set are taken one per cycle while busy is low (start high); the
// word flagged last closes the set, and up to 64 words are kept (any beyond
// that are dropped and every result of the set carries overflow). After the
// last word the block sorts the store with one shared comparator walking a
// single-port-write memory, one pass over L stored words for each L from the
// stored count n down to 2. The results then leave one per cycle behind a
// registered read of the first word, each held on the result port for exactly
// one cycle under result_strobe; the receiver cannot stall, so it must take
// every word as it comes. busy stays high from the cycle after the last word
// until the final result has been shown.
module bubble_sort_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bse_pkg::in_word_t item,
    output logic                   busy,
    output logic                   result_strobe,
    output bse_pkg::out_word_t     result
);
    import bse_pkg::*;

    // Element store, sequencer and datapath registers
    logic signed [DATA_W-1:0] store_reg [MAX_ITEMS];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         len_reg, len_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic                     ovf_reg, ovf_next;

    // Memory port controls
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0]        rd_addr;

    // Shared comparator and index arithmetic
    logic                     greater;
    logic [CNT_W-1:0]         idx_plus1;
    logic [CNT_W-1:0]         idx_plus2;
    logic [CNT_W-1:0]         len_minus1;
    logic                     accept;

    assign accept     = start && (state_reg == S_LOAD);
    assign greater    = cur_reg > rd_data_reg;
    assign idx_plus1  = {1'b0, idx_reg} + CNT_W'(1);
    assign idx_plus2  = {1'b0, idx_reg} + CNT_W'(2);
    assign len_minus1 = len_reg - CNT_W'(1);

    // Sequencer: load, bubble passes, emit
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        cur_next   = cur_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        wr_data    = item.value;
        rd_addr    = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        len_next = count_next;
                        if (count_next < CNT_W'(2))
                        begin
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            state_next = S_RD0;
                        end
                    end
                end
            end
            S_RD0:
            begin
                rd_addr    = '0;
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                cur_next   = rd_data_reg;
                rd_addr    = ADDR_W'(1);
                idx_next   = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // keep the larger word moving right, drop the smaller one in place
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (greater)
                begin
                    wr_data = rd_data_reg;
                end
                else
                begin
                    wr_data  = cur_reg;
                    cur_next = rd_data_reg;
                end
                if (idx_plus2 < len_reg)
                begin
                    rd_addr  = idx_plus2[ADDR_W-1:0];
                    idx_next = idx_plus1[ADDR_W-1:0];
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                wr_en    = 1'b1;
                wr_addr  = len_minus1[ADDR_W-1:0];
                wr_data  = cur_reg;
                len_next = len_minus1;
                if (len_minus1 < CNT_W'(2))
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_RD0;
                end
            end
            S_EMIT_RD:
            begin
                rd_addr    = '0;
                idx_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (idx_plus1 == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
                else
                begin
                    rd_addr  = idx_plus1[ADDR_W-1:0];
                    idx_next = idx_plus1[ADDR_W-1:0];
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Carried word of the current pass
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // Element store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_reg[rd_addr];
    end

    // Drive handshake and result word
    assign busy                 = (state_reg != S_LOAD);
    assign result_strobe        = (state_reg == S_EMIT);
    assign result.sorted_value  = rd_data_reg;
    assign result.last_res      = (idx_plus1 == count_reg);
    assign result.overflow      = ovf_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond store capacity");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result shown while idle");

    a_mid_set_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last) |=> !busy)
        else $error("block left load state before last word");

    a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last_res) |=> !busy)
        else $error("block still busy after final result");

    a_sort_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (len_reg >= CNT_W'(2) && len_reg <= count_reg))
        else $error("pass length out of range");
`endif

endmodule

`default_nettype wire

### verif/tb_bubble_sort_engine.sv
// Testbench for the bubble sort engine: random and directed sets, predicted sorted words checked.
`default_nettype none

module tb_bubble_sort_engine;
    import bse_pkg::*;

    localparam int TOTAL_WORDS  = 430;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic signed [DATA_W-1:0] MIN_V = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_V = 32'sh7fff_ffff;

    // Predicts the sorted stream of each set and checks emitted words in order
    class sort_checker;
        logic signed [DATA_W-1:0] held_vals [MAX_ITEMS];
        int                       held_count;
        bit                       dropped_seen;
        out_word_t                sorted_due [$];
        int                       errors;

        task report(input string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return sorted_due.size();
        endfunction

        // Store one loaded word; on the closing word queue the whole sorted set
        function void note_loaded(input in_word_t w);
            logic signed [DATA_W-1:0] tmp;
            out_word_t                o;
            int                       n;
            int                       p;
            int                       k;
            if (held_count < MAX_ITEMS)
            begin
                held_vals[held_count] = w.value;
                held_count++;
            end
            else
            begin
                dropped_seen = 1'b1;
            end
            if (w.last)
            begin
                n = held_count;
                // only a strictly greater left word moves right
                for (p = 0; p + 1 < n; p++)
                begin
                    for (k = 0; k + 1 < n - p; k++)
                    begin
                        if (held_vals[k] > held_vals[k+1])
                        begin
                            tmp            = held_vals[k];
                            held_vals[k]   = held_vals[k+1];
                            held_vals[k+1] = tmp;
                        end
                    end
                end
                for (k = 0; k < n; k++)
                begin
                    o.sorted_value = held_vals[k];
                    o.last_res     = (k == n - 1);
                    o.overflow     = dropped_seen;
                    sorted_due.push_back(o);
                end
                held_count   = 0;
                dropped_seen = 1'b0;
            end
        endfunction

        // Compare one emitted word against the oldest prediction
        task check_emitted(input out_word_t r);
            out_word_t want;
            if (sorted_due.size() == 0)
            begin
                report($sformatf("unexpected word value %0d last %0b overflow %0b",
                                 r.sorted_value, r.last_res, r.overflow));
                return;
            end
            want = sorted_due.pop_front();
            if (r.sorted_value !== want.sorted_value)
                report($sformatf("sorted_value got %0d want %0d",
                                 r.sorted_value, want.sorted_value));
            if (r.last_res !== want.last_res)
                report($sformatf("last_res got %b want %b", r.last_res, want.last_res));
            if (r.overflow !== want.overflow)
                report($sformatf("overflow got %b want %b", r.overflow, want.overflow));
        endtask
    endclass

    logic        clk    = 1'b0;
    logic        rst_n  = 1'b0;
    logic        start  = 1'b0;
    in_word_t    item   = '0;
    logic        busy;
    logic        result_strobe;
    out_word_t   result;

    sort_checker sb;
    int          cycles     = 0;
    int          burst_left = 0;

    bubble_sort_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always #5 clk = ~clk;

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_bubble_sort_engine: errors");
            $finish;
        end
    end

    // Check every strobed word; the block cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && result_strobe === 1'b1)
            sb.check_emitted(result);
    end

    // Drop start with noise on the word bus for a span set by n (n >= 1)
    task idle(input int n);
        start <= 1'b0;
        item  <= '{value: $urandom, last: 1'($urandom_range(0, 1))};
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every predicted word has been emitted
    task drain_wait();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Offer one word in bursts with random gaps, wait for it to be taken
    task send_word(input logic signed [DATA_W-1:0] v, input logic is_last);
        in_word_t w;
        int       gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle(gap);
        end
        burst_left--;
        w.value = v;
        w.last  = is_last;
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_loaded(w);
    endtask

    task send_set(input logic signed [DATA_W-1:0] vals [$]);
        int i;
        for (i = 0; i < vals.size(); i++)
            send_word(vals[i], i == vals.size() - 1);
    endtask

    // Favor extremes and a narrow band so duplicates show up often
    function logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return MIN_V;
            1:       return MAX_V;
            2, 3:    return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short sets, some long, a few full and a few over capacity
    function int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 88)
            return $urandom_range(9, 40);
        else if (r < 94)
            return MAX_ITEMS;
        else
            return $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
    endfunction

    initial
    begin
        logic signed [DATA_W-1:0] vals [$];
        int                       sent;
        int                       len;
        int                       k;
        sb   = new;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single extremes, mixed extremes, duplicates, reversed, presorted
        vals = {MIN_V};
        send_set(vals);
        vals = {MAX_V};
        send_set(vals);
        vals = {MAX_V, MIN_V, 32'sd0, -32'sd1, 32'sd1};
        send_set(vals);
        vals = {32'sd5, -32'sd5, 32'sd5, 32'sd5, MIN_V, MIN_V};
        send_set(vals);
        vals = {32'sd40, 32'sd30, 32'sd20, 32'sd10, 32'sd0, -32'sd10, -32'sd20};
        send_set(vals);
        vals = {-32'sd3, 32'sd7};
        send_set(vals);
        drain_wait();

        // Random sets, with an occasional full drain between them
        while (sent < TOTAL_WORDS)
        begin
            len = pick_len();
            for (k = 0; k < len; k++)
            begin
                send_word(pick_value(), k == len - 1);
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                drain_wait();
        end

        drain_wait();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_bubble_sort_engine: clean");
        else
            $display("tb_bubble_sort_engine: errors");
        $finish;
    end

endmodule

`default_nettype wire
